// File: rtl/heartbeat_challenge_supervisor_defines.svh
// Assertion macros shared by the supervisor RTL.
`ifndef HEARTBEAT_CHALLENGE_SUPERVISOR_DEFINES_SVH
`define HEARTBEAT_CHALLENGE_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hcs_pkg.sv
// Types, constants and codes for the heartbeat/challenge supervisor.
package hcs_pkg;

  localparam int TIMER_BITS     = 32;
  localparam int FAIL_BITS      = 8;
  localparam int INTERVAL_BITS  = 32;
  localparam int LIMIT_BITS     = 8;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int TIMER_CMP_BITS =
    (TIMER_BITS > INTERVAL_BITS) ? TIMER_BITS : INTERVAL_BITS;
  localparam int FAIL_CMP_BITS = (FAIL_BITS > LIMIT_BITS) ? FAIL_BITS : LIMIT_BITS;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEARTBEAT_ON       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHALLENGE_ON       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEARTBEAT_INTERVAL = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHALLENGE_INTERVAL = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FAILURE_LIMIT      = 3'd4;

  typedef enum logic [3:0] {
    PH_RESET      = 4'd0,
    PH_INIT       = 4'd1,
    PH_IDLE       = 4'd2,
    PH_HB_START   = 4'd3,
    PH_HB_WAIT    = 4'd4,
    PH_CH_START   = 4'd5,
    PH_CH_WAIT    = 4'd6,
    PH_FAIL_CHECK = 4'd7,
    PH_REC_START  = 4'd8,
    PH_REC_WAIT   = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_HB_START    = 3'd1,
    EV_HB_TIMEOUT  = 3'd2,
    EV_CHAL_START  = 3'd3,
    EV_CHAL_OK     = 3'd4,
    EV_CHAL_FAIL   = 3'd5,
    EV_RECOV_START = 3'd6,
    EV_RECOV_DONE  = 3'd7
  } event_t;

  typedef struct packed {
    logic                     heartbeat_on;
    logic                     challenge_on;
    logic [INTERVAL_BITS-1:0] heartbeat_interval;
    logic [INTERVAL_BITS-1:0] challenge_interval;
    logic [LIMIT_BITS-1:0]    failure_limit;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic [TIMER_BITS-1:0] hb_count;
    logic [TIMER_BITS-1:0] chal_count;
    logic [FAIL_BITS-1:0]  fail_count;
    logic                  fault_flag;
  } state_t;

  typedef struct packed {
    logic hb_timed_out;
    logic chal_busy;
    logic chal_done;
    logic chal_pass;
    logic recovery_done;
  } item_t;

  typedef struct packed {
    logic   hb_start_pulse;
    logic   chal_start_pulse;
    logic   event_valid;
    event_t event_code;
    logic   recovery_pulse;
    logic   fault_level;
  } result_t;

endpackage

// File: rtl/hcs_cfg.sv
// Configuration register bank of the supervisor.
module hcs_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hcs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output hcs_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcs_pkg::REG_HEARTBEAT_ON:       cfg.heartbeat_on <= cfg_data[0];
        hcs_pkg::REG_CHALLENGE_ON:       cfg.challenge_on <= cfg_data[0];
        hcs_pkg::REG_HEARTBEAT_INTERVAL:
          cfg.heartbeat_interval <= cfg_data[hcs_pkg::INTERVAL_BITS-1:0];
        hcs_pkg::REG_CHALLENGE_INTERVAL:
          cfg.challenge_interval <= cfg_data[hcs_pkg::INTERVAL_BITS-1:0];
        hcs_pkg::REG_FAILURE_LIMIT:
          cfg.failure_limit <= cfg_data[hcs_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/hcs_step.sv
// One supervisor step: next phase, counters and the result of the item.
module hcs_step (
  input  hcs_pkg::cfg_t    cfg,
  input  hcs_pkg::state_t  state,
  input  hcs_pkg::item_t   item,
  output hcs_pkg::state_t  state_next,
  output hcs_pkg::result_t result
);

  logic [hcs_pkg::TIMER_BITS-1:0] hb_inc;
  logic [hcs_pkg::TIMER_BITS-1:0] chal_inc;
  logic [hcs_pkg::FAIL_BITS-1:0]  fail_inc;
  logic                           hb_due;
  logic                           chal_due;
  logic                           limit_hit;
  logic                           chal_finished;
  hcs_pkg::phase_t                phase_next;

  // Saturating increments.
  assign hb_inc   = (&state.hb_count) ? state.hb_count
                                      : state.hb_count + hcs_pkg::TIMER_BITS'(1);
  assign chal_inc = (&state.chal_count) ? state.chal_count
                                        : state.chal_count + hcs_pkg::TIMER_BITS'(1);
  assign fail_inc = (&state.fail_count) ? state.fail_count
                                        : state.fail_count + hcs_pkg::FAIL_BITS'(1);

  assign hb_due = cfg.heartbeat_on &&
    (hcs_pkg::TIMER_CMP_BITS'(hb_inc) >=
     hcs_pkg::TIMER_CMP_BITS'(cfg.heartbeat_interval));
  assign chal_due = cfg.challenge_on &&
    (hcs_pkg::TIMER_CMP_BITS'(chal_inc) >=
     hcs_pkg::TIMER_CMP_BITS'(cfg.challenge_interval));
  assign limit_hit = (cfg.failure_limit == '0) ||
    (hcs_pkg::FAIL_CMP_BITS'(state.fail_count) >=
     hcs_pkg::FAIL_CMP_BITS'(cfg.failure_limit));
  assign chal_finished = item.chal_done && !item.chal_busy;

  always_comb begin
    phase_next = state.phase;
    unique case (state.phase)
      hcs_pkg::PH_RESET:    phase_next = hcs_pkg::PH_INIT;
      hcs_pkg::PH_INIT:     phase_next = hcs_pkg::PH_IDLE;
      hcs_pkg::PH_IDLE: begin
        // Heartbeat wins when both checks are due.
        if (hb_due) begin
          phase_next = hcs_pkg::PH_HB_START;
        end else if (chal_due) begin
          phase_next = hcs_pkg::PH_CH_START;
        end
      end
      hcs_pkg::PH_HB_START: phase_next = hcs_pkg::PH_HB_WAIT;
      hcs_pkg::PH_HB_WAIT:
        phase_next = item.hb_timed_out ? hcs_pkg::PH_FAIL_CHECK : hcs_pkg::PH_IDLE;
      hcs_pkg::PH_CH_START: phase_next = hcs_pkg::PH_CH_WAIT;
      hcs_pkg::PH_CH_WAIT: begin
        if (chal_finished) begin
          phase_next = item.chal_pass ? hcs_pkg::PH_IDLE : hcs_pkg::PH_FAIL_CHECK;
        end
      end
      hcs_pkg::PH_FAIL_CHECK:
        phase_next = limit_hit ? hcs_pkg::PH_REC_START : hcs_pkg::PH_IDLE;
      hcs_pkg::PH_REC_START: phase_next = hcs_pkg::PH_REC_WAIT;
      hcs_pkg::PH_REC_WAIT: begin
        if (item.recovery_done) begin
          phase_next = hcs_pkg::PH_INIT;
        end
      end
      default: phase_next = hcs_pkg::PH_RESET;
    endcase
  end

  always_comb begin
    state_next            = state;
    state_next.phase      = phase_next;
    result                = '0;
    result.event_code     = hcs_pkg::EV_NONE;
    unique case (state.phase)
      hcs_pkg::PH_RESET, hcs_pkg::PH_INIT: begin
        state_next.hb_count   = '0;
        state_next.chal_count = '0;
        state_next.fail_count = '0;
        state_next.fault_flag = 1'b0;
      end
      hcs_pkg::PH_IDLE: begin
        state_next.hb_count   = hb_inc;
        state_next.chal_count = chal_inc;
      end
      hcs_pkg::PH_HB_START: begin
        result.hb_start_pulse = 1'b1;
        result.event_valid    = 1'b1;
        result.event_code     = hcs_pkg::EV_HB_START;
      end
      hcs_pkg::PH_HB_WAIT: begin
        if (item.hb_timed_out) begin
          result.event_valid    = 1'b1;
          result.event_code     = hcs_pkg::EV_HB_TIMEOUT;
          state_next.fail_count = fail_inc;
        end else begin
          state_next.hb_count = '0;
        end
      end
      hcs_pkg::PH_CH_START: begin
        result.chal_start_pulse = 1'b1;
        result.event_valid      = 1'b1;
        result.event_code       = hcs_pkg::EV_CHAL_START;
      end
      hcs_pkg::PH_CH_WAIT: begin
        if (chal_finished) begin
          result.event_valid = 1'b1;
          if (item.chal_pass) begin
            result.event_code     = hcs_pkg::EV_CHAL_OK;
            state_next.chal_count = '0;
          end else begin
            result.event_code     = hcs_pkg::EV_CHAL_FAIL;
            state_next.fail_count = fail_inc;
          end
        end
      end
      hcs_pkg::PH_FAIL_CHECK: ;
      hcs_pkg::PH_REC_START: begin
        result.recovery_pulse = 1'b1;
        result.event_valid    = 1'b1;
        result.event_code     = hcs_pkg::EV_RECOV_START;
        state_next.fault_flag = 1'b1;
      end
      hcs_pkg::PH_REC_WAIT: begin
        if (item.recovery_done) begin
          result.event_valid    = 1'b1;
          result.event_code     = hcs_pkg::EV_RECOV_DONE;
          state_next.fail_count = '0;
          state_next.fault_flag = 1'b0;
        end
      end
      default: ;
    endcase
    result.fault_level = state_next.fault_flag;
  end

endmodule

// File: rtl/heartbeat_challenge_supervisor.sv
// Heartbeat/challenge supervisor top level: state, result register, handshakes.
//
// Each accepted input item is one supervisor tick. The item carries the
// heartbeat monitor, challenge engine and recovery status; the block answers
// with exactly one result item holding the start pulses, the event code and
// the fault level after that tick.
// Input channel: in_valid / in_stall with one port per field. Output channel:
// out_valid / out_stall, likewise. Configuration: cfg_we, cfg_index, cfg_data,
// to be used only while no item is in flight.
// The result appears on the output register in the cycle after the item is
// accepted. Throughput: one item per cycle unless the receiver stalls; the
// step logic between the state registers and result register is a single pass.
// When the receiver stalls with a result waiting, in_stall rises in the same
// cycle and the result is held until taken.
// Synchronous reset (rst) clears the configuration registers, the phase (to
// its reset phase), the timers, the failure count, the fault flag and the
// output valid.
`include "heartbeat_challenge_supervisor_defines.svh"

module heartbeat_challenge_supervisor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hcs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               hb_timed_out,
  input  logic                               chal_busy,
  input  logic                               chal_done,
  input  logic                               chal_pass,
  input  logic                               recovery_done,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hb_start_pulse,
  output logic                               chal_start_pulse,
  output logic                               event_valid,
  output logic [2:0]                         event_code,
  output logic                               recovery_pulse,
  output logic                               fault_level
);

  hcs_pkg::cfg_t    cfg;
  hcs_pkg::state_t  state;
  hcs_pkg::state_t  state_next;
  hcs_pkg::item_t   item;
  hcs_pkg::result_t result_next;
  hcs_pkg::result_t result;
  logic             accept;

  hcs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign item.hb_timed_out  = hb_timed_out;
  assign item.chal_busy     = chal_busy;
  assign item.chal_done     = chal_done;
  assign item.chal_pass     = chal_pass;
  assign item.recovery_done = recovery_done;

  hcs_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result_next)
  );

  // Hold off the sender only while a result waits on a stalled receiver.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= hcs_pkg::PH_RESET;
      state.hb_count   <= '0;
      state.chal_count <= '0;
      state.fail_count <= '0;
      state.fault_flag <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign hb_start_pulse   = result.hb_start_pulse;
  assign chal_start_pulse = result.chal_start_pulse;
  assign event_valid      = result.event_valid;
  assign event_code       = result.event_code;
  assign recovery_pulse   = result.recovery_pulse;
  assign fault_level      = result.fault_level;

  `HCS_ASSERT_NOW(a_code_none_without_event,
    out_valid && !event_valid, event_code == hcs_pkg::EV_NONE,
    "event code set without event_valid")
  `HCS_ASSERT_NOW(a_recovery_pulse_raises_fault,
    out_valid && recovery_pulse,
    fault_level && event_valid && event_code == hcs_pkg::EV_RECOV_START,
    "recovery pulse without fault and recovery start event")
  `HCS_ASSERT_NOW(a_single_pulse,
    out_valid, !(hb_start_pulse && chal_start_pulse) && !(hb_start_pulse && recovery_pulse)
    && !(chal_start_pulse && recovery_pulse),
    "more than one start pulse in a result")
  `HCS_ASSERT_NEXT(a_recovery_done_clears,
    accept && state.phase == hcs_pkg::PH_REC_WAIT && recovery_done,
    state.phase == hcs_pkg::PH_INIT && state.fail_count == '0 && !state.fault_flag
    && out_valid && event_code == hcs_pkg::EV_RECOV_DONE,
    "recovery completion did not clear failures and fault")

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the heartbeat/challenge supervisor.
module tb_top;
  import hcs_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int HOLD_CYCLES   = 60;
  localparam int HOLD_AT_TICK  = 60;
  localparam int TICKS_PER_SET = 115;
  localparam int NUM_SETTINGS  = 6;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      hb_timed_out;
  logic                      chal_busy;
  logic                      chal_done;
  logic                      chal_pass;
  logic                      recovery_done;
  logic                      out_valid;
  logic                      out_stall;
  logic                      hb_start_pulse;
  logic                      chal_start_pulse;
  logic                      event_valid;
  logic [2:0]                event_code;
  logic                      recovery_pulse;
  logic                      fault_level;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int ticks_in       = 0;
  int quiet          = 0;
  int hold_left      = 0;
  bit hold_used      = 1'b0;

  heartbeat_challenge_supervisor uut (.*);

  always #5 clk = ~clk;

  class tick_scoreboard;
    cfg_t                  cfg;
    phase_t                phase;
    logic [TIMER_BITS-1:0] hb_timer;
    logic [TIMER_BITS-1:0] chal_timer;
    logic [FAIL_BITS-1:0]  fails;
    logic                  fault;
    result_t               pending_results[$];
    int                    errors;
    int                    results_seen;
    int                    event_seen[8];

    function new();
      cfg = '0;
      phase = PH_RESET;
      clear_counters();
      errors = 0;
      results_seen = 0;
      foreach (event_seen[i]) event_seen[i] = 0;
    endfunction

    function void clear_counters();
      hb_timer = '0;
      chal_timer = '0;
      fails = '0;
      fault = 1'b0;
    endfunction

    function logic [TIMER_BITS-1:0] bump_timer(logic [TIMER_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function logic [FAIL_BITS-1:0] bump_fails(logic [FAIL_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    // One supervisor tick: update the state and return the result it causes.
    function result_t advance_supervisor(item_t it);
      result_t r;
      r = '0;
      r.event_code = EV_NONE;
      case (phase)
        PH_RESET: begin
          clear_counters();
          phase = PH_INIT;
        end
        PH_INIT: begin
          clear_counters();
          phase = PH_IDLE;
        end
        PH_IDLE: begin
          hb_timer = bump_timer(hb_timer);
          chal_timer = bump_timer(chal_timer);
          if (cfg.heartbeat_on && hb_timer >= cfg.heartbeat_interval) begin
            phase = PH_HB_START;
          end else if (cfg.challenge_on && chal_timer >= cfg.challenge_interval) begin
            phase = PH_CH_START;
          end
        end
        PH_HB_START: begin
          r.hb_start_pulse = 1'b1;
          r.event_valid = 1'b1;
          r.event_code = EV_HB_START;
          phase = PH_HB_WAIT;
        end
        PH_HB_WAIT: begin
          if (!it.hb_timed_out) begin
            hb_timer = '0;
            phase = PH_IDLE;
          end else begin
            r.event_valid = 1'b1;
            r.event_code = EV_HB_TIMEOUT;
            fails = bump_fails(fails);
            phase = PH_FAIL_CHECK;
          end
        end
        PH_CH_START: begin
          r.chal_start_pulse = 1'b1;
          r.event_valid = 1'b1;
          r.event_code = EV_CHAL_START;
          phase = PH_CH_WAIT;
        end
        PH_CH_WAIT: begin
          // outcome counts only once the engine is done and no longer busy
          if (!it.chal_busy && it.chal_done) begin
            r.event_valid = 1'b1;
            if (it.chal_pass) begin
              r.event_code = EV_CHAL_OK;
              chal_timer = '0;
              phase = PH_IDLE;
            end else begin
              r.event_code = EV_CHAL_FAIL;
              fails = bump_fails(fails);
              phase = PH_FAIL_CHECK;
            end
          end
        end
        PH_FAIL_CHECK: begin
          if (cfg.failure_limit == 0 || fails >= cfg.failure_limit) phase = PH_REC_START;
          else phase = PH_IDLE;
        end
        PH_REC_START: begin
          r.recovery_pulse = 1'b1;
          r.event_valid = 1'b1;
          r.event_code = EV_RECOV_START;
          fault = 1'b1;
          phase = PH_REC_WAIT;
        end
        PH_REC_WAIT: begin
          if (it.recovery_done) begin
            r.event_valid = 1'b1;
            r.event_code = EV_RECOV_DONE;
            fails = '0;
            fault = 1'b0;
            phase = PH_INIT;
          end
        end
        default: phase = PH_RESET;
      endcase
      r.fault_level = fault;
      return r;
    endfunction

    function void note_tick(item_t it);
      pending_results.push_back(advance_supervisor(it));
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
      end
    endfunction

    function void check_tick_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %h", $time, got);
        return;
      end
      exp = pending_results.pop_front();
      results_seen++;
      event_seen[exp.event_code]++;
      check_field("hb_start_pulse", exp.hb_start_pulse, got.hb_start_pulse);
      check_field("chal_start_pulse", exp.chal_start_pulse, got.chal_start_pulse);
      check_field("event_valid", exp.event_valid, got.event_valid);
      check_field("event_code", exp.event_code, got.event_code);
      check_field("recovery_pulse", exp.recovery_pulse, got.recovery_pulse);
      check_field("fault_level", exp.fault_level, got.fault_level);
    endfunction
  endclass

  tick_scoreboard sb = new();

  // Watch both channels and feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_tick({hb_timed_out, chal_busy, chal_done, chal_pass, recovery_done});
        ticks_in <= ticks_in + 1;
      end
      if (out_valid && !out_stall) begin
        sb.check_tick_result({hb_start_pulse, chal_start_pulse, event_valid,
                              event_code, recovery_pulse, fault_level});
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_used && ticks_in >= HOLD_AT_TICK) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, quiet);
    $display("[heartbeat_challenge_supervisor] ERROR");
    $finish;
  end

  task automatic offer_tick(item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {hb_timed_out, chal_busy, chal_done, chal_pass, recovery_done} <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Upper data bits are junk on the narrow registers; the block must drop them.
  task automatic write_settings(cfg_t c);
    put_reg(REG_HEARTBEAT_ON, ($urandom() & ~32'h1) | c.heartbeat_on);
    put_reg(REG_CHALLENGE_ON, ($urandom() & ~32'h1) | c.challenge_on);
    put_reg(REG_HEARTBEAT_INTERVAL, c.heartbeat_interval);
    put_reg(REG_CHALLENGE_INTERVAL, c.challenge_interval);
    put_reg(REG_FAILURE_LIMIT, ($urandom() & ~32'hFF) | c.failure_limit);
    cfg_we <= 1'b0;
    sb.cfg = c;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic cfg_t setting_for(int s);
    cfg_t c;
    c = '0;
    case (s)
      0: c = '{1'b1, 1'b1, 32'd0, 32'd0, 8'd0};
      1: c = '{1'b1, 1'b0, 32'd3, 32'hFFFF_FFFF, 8'd2};
      2: c = '{1'b0, 1'b1, 32'hFFFF_FFFF, 32'd5, 8'd1};
      3: c = '{1'b1, 1'b1, 32'hFFFF_FFFF, 32'd2, 8'd255};
      4: c = '{1'b1, 1'b1, 32'd7, 32'd4, 8'd3};
      default: begin
        c.heartbeat_on = 1'($urandom_range(0, 1));
        c.challenge_on = 1'($urandom_range(0, 1));
        c.heartbeat_interval = INTERVAL_BITS'($urandom_range(0, 12));
        c.challenge_interval = INTERVAL_BITS'($urandom_range(0, 12));
        c.failure_limit = LIMIT_BITS'($urandom_range(0, 4));
      end
    endcase
    return c;
  endfunction

  // Mostly plausible engine behavior, some fully random noise.
  function automatic item_t random_tick();
    item_t it;
    if ($urandom_range(0, 9) == 0) return item_t'(5'($urandom()));
    it.hb_timed_out = ($urandom_range(0, 99) < 35);
    it.chal_busy = ($urandom_range(0, 99) < 40);
    it.chal_done = ($urandom_range(0, 99) < 45);
    it.chal_pass = ($urandom_range(0, 99) < 55);
    it.recovery_done = ($urandom_range(0, 99) < 30);
    return it;
  endfunction

  item_t directed_ticks[25] = '{
    5'b00000, 5'b11111, 5'b00000, 5'b00000, 5'b01100,
    5'b00100, 5'b00000, 5'b00000, 5'b11110, 5'b00001,
    5'b00000, 5'b00000, 5'b00000, 5'b00110, 5'b00000,
    5'b00000, 5'b10000, 5'b00000, 5'b00000, 5'b00001,
    5'b00000, 5'b00000, 5'b00000, 5'b00010, 5'b00110
  };

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    {hb_timed_out, chal_busy, chal_done, chal_pass, recovery_done} <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 19;
    recv_stall_pct = 78;
    write_settings('{1'b1, 1'b1, 32'd2, 32'd0, 8'd0});
    foreach (directed_ticks[i]) offer_tick(directed_ticks[i]);
    drain();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s == 2) begin
        send_idle_pct = 78;
        recv_stall_pct = 19;
      end else if (s == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_settings(setting_for(s));
      repeat (TICKS_PER_SET) offer_tick(random_tick());
      drain();
    end

    $display("Covered %0d ticks over %0d register settings, results checked: %0d",
             ticks_in, NUM_SETTINGS + 1, sb.results_seen);
    $display("Events: none %0d, hb %0d/%0d, chal %0d/%0d/%0d, recovery %0d/%0d",
             sb.event_seen[EV_NONE], sb.event_seen[EV_HB_START],
             sb.event_seen[EV_HB_TIMEOUT], sb.event_seen[EV_CHAL_START],
             sb.event_seen[EV_CHAL_OK], sb.event_seen[EV_CHAL_FAIL],
             sb.event_seen[EV_RECOV_START], sb.event_seen[EV_RECOV_DONE]);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[heartbeat_challenge_supervisor] OK");
    end else begin
      $display("[heartbeat_challenge_supervisor] ERROR");
    end
    $finish;
  end
endmodule
